@@ sv/atb_pkg.sv @@
package atb_pkg;

    localparam int CAP_W   = 49;
    localparam int BLK_W   = 48;
    localparam int LBA28_W = 28;

    // Requests in flight: pipeline plus queued, bounded by the credit count
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // floor(2^32 / 63); the quotient estimate is low by at most one
    localparam logic [26:0] RECIP_63 = 27'd68174084;
    localparam int          RECIP_SH = 32;
    localparam int          QUOT_W   = 23;

    localparam logic [6:0] CHS_SECTORS = 7'd63;

    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;

    localparam logic [2:0] SEL_LBA_TAG = 3'b111;
    localparam logic [2:0] SEL_CHS_TAG = 3'b101;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CAPACITY = 2'd1,
        ST_LBA48    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        RI_SELECT  = 3'd0,
        RI_CONTROL = 3'd1,
        RI_COUNT   = 3'd2,
        RI_LBA0    = 3'd3,
        RI_LBA1    = 3'd4,
        RI_LBA2    = 3'd5,
        RI_COMMAND = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [CAP_W-1:0] cap_primary;
        logic [CAP_W-1:0] cap_secondary;
        logic             lba_primary;
        logic             lba_secondary;
    } cfg_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] sel;
        logic [7:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] cmd;
    } entry_t;

    typedef struct packed {
        status_t    status;
        reg_index_t reg_index;
        logic [7:0] reg_data;
        logic       last;
    } result_t;

endpackage

@@ sv/atb_calc.sv @@
module atb_calc
    import atb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             mode,
    input  logic             drive_secondary,
    input  logic [BLK_W-1:0] start_block,
    input  logic [7:0]       block_count,
    input  cfg_t             cfg,
    output logic             out_valid,
    output entry_t           out_entry
);

    // stage 1: captured request
    logic             s1_valid_reg;
    logic             s1_wr_reg;
    logic             s1_sec_reg;
    logic [BLK_W-1:0] s1_blk_reg;
    logic [7:0]       s1_cnt_reg;

    // stage 2: checks and reciprocal product
    logic               s2_valid_reg;
    logic               s2_wr_reg;
    logic               s2_sec_reg;
    logic               s2_lba_reg;
    logic               s2_err_cap_reg;
    logic               s2_err_lba_reg;
    logic [LBA28_W-1:0] s2_blk_reg;
    logic [7:0]         s2_cnt_reg;
    logic [QUOT_W-1:0]  s2_q0_reg;

    // stage 3: finished entry
    logic   s3_valid_reg;
    entry_t s3_entry_reg;

    logic [CAP_W-1:0]   s1_cap;
    logic               s1_lba;
    logic [CAP_W-1:0]   s1_end;
    logic               s2_err_cap_next;
    logic               s2_err_lba_next;
    logic [54:0]        s1_prod;
    logic [QUOT_W-1:0]  s2_q0_next;

    logic [29:0]        s2_rem_wide;
    logic [6:0]         s2_rem0;
    logic               s2_fix;
    logic [QUOT_W-1:0]  s2_quot;
    logic [6:0]         s2_rem;
    logic [7:0]         s2_sector;
    entry_t             s3_entry_next;

    assign s1_cap = s1_sec_reg ? cfg.cap_secondary : cfg.cap_primary;
    assign s1_lba = s1_sec_reg ? cfg.lba_secondary : cfg.lba_primary;
    assign s1_end = {1'b0, s1_blk_reg} + {{(CAP_W-8){1'b0}}, s1_cnt_reg};
    assign s2_err_cap_next = s1_end > s1_cap;
    assign s2_err_lba_next = |s1_blk_reg[BLK_W-1:LBA28_W];
    assign s1_prod = s1_blk_reg[LBA28_W-1:0] * RECIP_63;
    assign s2_q0_next = s1_prod[RECIP_SH +: QUOT_W];

    // remainder of the estimate lies in [0, 126): one correction step
    assign s2_rem_wide = {2'b00, s2_blk_reg} - {1'b0, s2_q0_reg, 6'b0}
                         + {7'b0, s2_q0_reg};
    assign s2_rem0 = s2_rem_wide[6:0];
    assign s2_fix  = s2_rem0 >= CHS_SECTORS;
    assign s2_quot = s2_q0_reg + {{(QUOT_W-1){1'b0}}, s2_fix};
    assign s2_rem  = s2_fix ? (s2_rem0 - CHS_SECTORS) : s2_rem0;
    assign s2_sector = {1'b0, s2_rem} + 8'd1;

    always_comb
    begin
        s3_entry_next.cnt = s2_cnt_reg;
        s3_entry_next.cmd = s2_wr_reg ? CMD_WRITE : CMD_READ;
        if (s2_err_cap_reg)
        begin
            s3_entry_next.status = ST_CAPACITY;
        end
        else if (s2_err_lba_reg)
        begin
            s3_entry_next.status = ST_LBA48;
        end
        else
        begin
            s3_entry_next.status = ST_OK;
        end
        if (s2_lba_reg)
        begin
            s3_entry_next.sel = {SEL_LBA_TAG, s2_sec_reg, s2_blk_reg[27:24]};
            s3_entry_next.b0  = s2_blk_reg[7:0];
            s3_entry_next.b1  = s2_blk_reg[15:8];
            s3_entry_next.b2  = s2_blk_reg[23:16];
        end
        else
        begin
            // head = quotient mod 16, cylinder = quotient / 16 cut to 16 bits
            s3_entry_next.sel = {SEL_CHS_TAG, s2_sec_reg, s2_quot[3:0]};
            s3_entry_next.b0  = s2_sector;
            s3_entry_next.b1  = s2_quot[11:4];
            s3_entry_next.b2  = s2_quot[19:12];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_wr_reg  <= mode;
            s1_sec_reg <= drive_secondary;
            s1_blk_reg <= start_block;
            s1_cnt_reg <= block_count;
        end
        if (s1_valid_reg)
        begin
            s2_wr_reg      <= s1_wr_reg;
            s2_sec_reg     <= s1_sec_reg;
            s2_lba_reg     <= s1_lba;
            s2_err_cap_reg <= s2_err_cap_next;
            s2_err_lba_reg <= s2_err_lba_next;
            s2_blk_reg     <= s1_blk_reg[LBA28_W-1:0];
            s2_cnt_reg     <= s1_cnt_reg;
            s2_q0_reg      <= s2_q0_next;
        end
        if (s2_valid_reg)
        begin
            s3_entry_reg <= s3_entry_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_entry = s3_entry_reg;

endmodule

@@ sv/atb_queue.sv @@
module atb_queue
    import atb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    output logic    pop,
    output logic    res_valid,
    output result_t res
);

    entry_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    reg_index_t           step_reg;
    reg_index_t           step_next;
    logic                 res_valid_reg;
    result_t              res_reg;
    result_t              res_next;

    entry_t               head;
    logic                 empty;
    logic                 head_err;

    assign head     = mem_reg[rd_ptr_reg];
    assign empty    = count_reg == '0;
    assign head_err = head.status != ST_OK;
    assign pop      = !empty && (head_err || step_reg == RI_COMMAND);

    always_comb
    begin
        count_next = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        if (pop)
        begin
            step_next = RI_SELECT;
        end
        else if (!empty)
        begin
            step_next = reg_index_t'(step_reg + 3'd1);
        end
        else
        begin
            step_next = step_reg;
        end
    end

    always_comb
    begin
        res_next.status    = head.status;
        res_next.reg_index = step_reg;
        res_next.last      = pop;
        unique case (step_reg)
            RI_SELECT:  res_next.reg_data = head.sel;
            RI_CONTROL: res_next.reg_data = 8'h00;
            RI_COUNT:   res_next.reg_data = head.cnt;
            RI_LBA0:    res_next.reg_data = head.b0;
            RI_LBA1:    res_next.reg_data = head.b1;
            RI_LBA2:    res_next.reg_data = head.b2;
            RI_COMMAND: res_next.reg_data = head.cmd;
            default:    res_next.reg_data = 8'h00;
        endcase
        // rejected request: a single status-only result
        if (head_err)
        begin
            res_next.reg_index = RI_SELECT;
            res_next.reg_data  = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            step_reg      <= RI_SELECT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg     <= count_next;
            step_reg      <= step_next;
            res_valid_reg <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
        if (!empty)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != Q_CNT_W'(Q_DEPTH)))
        else $error("request queue overflow");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.last) |-> $past(pop))
        else $error("last result without queue pop");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.last) |=>
            (res_valid_reg && res_reg.reg_index == $past(res_reg.reg_index) + 3'd1))
        else $error("register write burst broken");

endmodule

@@ sv/ata_taskfile_builder.sv @@
// A request passes the calc stages s1, s2 and s3, the queue and the result register;
// an accepted request yields 7 writes on consecutive cycles, a rejected one 1.
// The one-per-cycle result port sets the sustained rate; new requests are taken while
// earlier ones drain, and up to 4 requests are held in the 3-stage pipeline and queue.
// busy is high while all 4 request slots are taken. Reset clears the pipeline,
// queue and credits; capacities reset to 0, both drives to LBA mode.
module ata_taskfile_builder
    import atb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             mode,
    input  logic             drive_secondary,
    input  logic [BLK_W-1:0] start_block,
    input  logic [7:0]       block_count,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CAP_W-1:0] cfg_data,
    output logic             strobe,
    output logic [1:0]       status,
    output logic [2:0]       reg_index,
    output logic [7:0]       reg_data,
    output logic             last
);

    localparam logic [1:0] CFG_CAP_PRIMARY   = 2'd0;
    localparam logic [1:0] CFG_CAP_SECONDARY = 2'd1;
    localparam logic [1:0] CFG_LBA_PRIMARY   = 2'd2;
    localparam logic [1:0] CFG_LBA_SECONDARY = 2'd3;

    cfg_t               cfg_reg;
    logic [Q_CNT_W-1:0] cred_reg;
    logic [Q_CNT_W-1:0] cred_next;

    logic    accept;
    logic    calc_valid;
    entry_t  calc_entry;
    logic    pop;
    logic    res_valid;
    result_t res;

    assign busy   = cred_reg == Q_CNT_W'(Q_DEPTH);
    assign accept = start && !busy;
    assign cred_next = cred_reg + Q_CNT_W'(accept) - Q_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cap_primary   <= '0;
            cfg_reg.cap_secondary <= '0;
            cfg_reg.lba_primary   <= 1'b1;
            cfg_reg.lba_secondary <= 1'b1;
            cred_reg              <= '0;
        end
        else
        begin
            cred_reg <= cred_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CAP_PRIMARY:   cfg_reg.cap_primary   <= cfg_data;
                    CFG_CAP_SECONDARY: cfg_reg.cap_secondary <= cfg_data;
                    CFG_LBA_PRIMARY:   cfg_reg.lba_primary   <= cfg_data[0];
                    CFG_LBA_SECONDARY: cfg_reg.lba_secondary <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    atb_calc u_calc (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (accept),
        .mode            (mode),
        .drive_secondary (drive_secondary),
        .start_block     (start_block),
        .block_count     (block_count),
        .cfg             (cfg_reg),
        .out_valid       (calc_valid),
        .out_entry       (calc_entry)
    );

    atb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (calc_valid),
        .push_entry (calc_entry),
        .pop        (pop),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign strobe    = res_valid;
    assign status    = res.status;
    assign reg_index = res.reg_index;
    assign reg_data  = res.reg_data;
    assign last      = res.last;

    a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cred_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("request credits exceed slots");

    a_pop_has_cred: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cred_reg != '0))
        else $error("request retired without credit");

endmodule
